// ----- rtl/lpr_pkg.sv -----
package lpr_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 16;
	localparam int SLOT_W     = 3;
	localparam int RANK_W     = 3;
	localparam int FILL_W     = 4;
	localparam int CNT_W      = 16;
	localparam int CFG_W      = 4;
	localparam int OUT_BITS   = 56;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [FILL_W-1:0]    fill_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CFG_W-1:0]     cfg_t;

	// lookup results accumulated along the cell row
	typedef struct packed {
		logic  found;
		slot_t found_slot;
		rank_t found_rank;
		slot_t best_slot;
		rank_t best_rank;
		page_t best_page;
	} chain_t;

	// update broadcast to every cell when a transaction is taken
	typedef struct packed {
		logic  en;
		logic  clear;
		logic  load;
		slot_t slot;
		rank_t r;
	} cmd_t;

endpackage

// ----- rtl/lru_page_replacement.sv -----
// LRU page replacement over up to eight page frames.
// Input stream: s_tdata carries one page reference per transaction, s_tlast
// marks the final reference of a stream. Output stream: one result per
// reference, m_tlast echoes the input mark and the totals in that result are
// final; frames and totals are cleared right after it.
// Each frame is a cell in a row; the lookup result (first match, least
// recent frame) ripples along the row and the update is broadcast back.
// The result is registered; one reference is taken every cycle while the
// output register is free or taken, set by the row's match and rank update.
// The result sits in an output register: while the receiver stalls the
// register holds, and input is refused until it is taken or freed in the
// same cycle.
// The config channel writes frames_in_use (0 acts as 1, above 8 as 8); write
// it only between streams when nothing is in flight.
// Reset (arst_n low) empties all frames, clears totals and sets
// frames_in_use to 4; no pass over the frames is needed.
module lru_page_replacement (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] page_number
	input  logic        s_tlast,   // last_reference
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [0] hit, [3:1] frame_slot, [4] evicted_valid,
	                               // [20:5] evicted_page, [36:21] hit_total,
	                               // [52:37] miss_total, [55:53] zero
	output logic        m_tlast,   // stream_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // frames_in_use
);
	import lpr_pkg::*;

	cfg_t   frames_in_use_q;
	fill_t  filled_q;
	cnt_t   hit_q;
	cnt_t   miss_q;
	logic   out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;
	logic   out_last_q;

	chain_t chain [MAX_FRAMES+1];
	cmd_t   cmd;
	page_t  page;
	fill_t  limit;
	logic   accept;
	logic   found;
	logic   fill;
	logic   ev_valid;
	page_t  ev_page;
	slot_t  slot;
	rank_t  r;
	cnt_t   hit_n;
	cnt_t   miss_n;

	assign page      = s_tdata[PAGE_BITS-1:0];
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tlast   = out_last_q;

	always_comb begin
		if (frames_in_use_q == '0) begin
			limit = fill_t'(1);
		end else if (frames_in_use_q > cfg_t'(MAX_FRAMES)) begin
			limit = fill_t'(MAX_FRAMES);
		end else begin
			limit = fill_t'(frames_in_use_q);
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		lpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (slot_t'(i)),
			.page      (page),
			.filled    (filled_q),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign found    = chain[MAX_FRAMES].found;
	assign fill     = !found && (filled_q < limit);
	assign ev_valid = !found && !fill;
	assign ev_page  = ev_valid ? chain[MAX_FRAMES].best_page : '0;

	always_comb begin
		priority if (found) begin
			slot = chain[MAX_FRAMES].found_slot;
			r    = chain[MAX_FRAMES].found_rank;
		end else if (fill) begin
			slot = filled_q[SLOT_W-1:0];
			r    = filled_q[RANK_W-1:0];
		end else begin
			slot = chain[MAX_FRAMES].best_slot;
			r    = chain[MAX_FRAMES].best_rank;
		end
	end

	assign cmd.en    = accept;
	assign cmd.clear = s_tlast;
	assign cmd.load  = !found;
	assign cmd.slot  = slot;
	assign cmd.r     = r;

	// saturate totals at all ones
	assign hit_n  = (found && (hit_q != '1)) ? hit_q + 1'b1 : hit_q;
	assign miss_n = (!found && (miss_q != '1)) ? miss_q + 1'b1 : miss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= cfg_t'(4);
			filled_q        <= '0;
			hit_q           <= '0;
			miss_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				frames_in_use_q <= cfg_data;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
				if (s_tlast) begin
					filled_q <= '0;
					hit_q    <= '0;
					miss_q   <= '0;
				end else begin
					filled_q <= fill ? filled_q + 1'b1 : filled_q;
					hit_q    <= hit_n;
					miss_q   <= miss_n;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {3'b000, miss_n, hit_n, ev_page, ev_valid, slot, found};
			out_last_q <= s_tlast;
		end
	end

endmodule

// ----- rtl/lpr_cell.sv -----
module lpr_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  lpr_pkg::slot_t  cell_idx,
	input  lpr_pkg::page_t  page,
	input  lpr_pkg::fill_t  filled,
	input  lpr_pkg::cmd_t   cmd,
	input  lpr_pkg::chain_t chain_in,
	output lpr_pkg::chain_t chain_out
);
	import lpr_pkg::*;

	page_t page_q;
	rank_t rank_q;
	logic  valid;
	logic  match;

	assign valid = {1'b0, cell_idx} < filled;
	assign match = valid && (page_q == page);

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && match) begin
			chain_out.found      = 1'b1;
			chain_out.found_slot = cell_idx;
			chain_out.found_rank = rank_q;
		end
		// the first cell, once filled, always seeds the oldest candidate, so a lone frame can be evicted
		if (valid && ((cell_idx == '0) || (rank_q > chain_in.best_rank))) begin
			chain_out.best_slot = cell_idx;
			chain_out.best_rank = rank_q;
			chain_out.best_page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (cmd.en) begin
			if (cmd.clear) begin
				rank_q <= '0;
			end else if (cell_idx == cmd.slot) begin
				rank_q <= '0;
			end else if (valid && (rank_q < cmd.r)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en && cmd.load && (cell_idx == cmd.slot)) begin
			page_q <= page;
		end
	end

endmodule

// ----- sim/tb_lru_page_replacement.sv -----
module tb_lru_page_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	import lpr_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int CHUNK_REFS  = 62;

	typedef struct {
		page_t page;
		logic  last;
	} page_ref_t;

	typedef struct {
		logic  hit;
		slot_t slot;
		logic  ev_valid;
		page_t ev_page;
		cnt_t  hits;
		cnt_t  misses;
		logic  stream_end;
	} lru_outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] page_number
	logic        s_tlast;   // last_reference
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [0] hit, [3:1] frame_slot, [4] evicted_valid, [20:5] evicted_page,
	                        // [36:21] hit_total, [52:37] miss_total, [55:53] zero
	logic        m_tlast;   // stream_end
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;  // frames_in_use

	// shadow of the frame table
	page_t frame_page [MAX_FRAMES];
	rank_t frame_rank [MAX_FRAMES];
	fill_t filled;
	cnt_t  hit_cnt;
	cnt_t  miss_cnt;
	cfg_t  frames_cfg;

	page_ref_t    ref_q [$];
	lru_outcome_t outcome_q [$];

	logic ref_taken;
	int   src_idle_pct;
	int   snk_stall_pct;
	int   err_cnt;
	int   results_seen;
	int   hits_seen;
	int   evicts_seen;
	int   streams_seen;
	int   cfg_writes;

	lru_page_replacement DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void flush_frames();
		for (int i = 0; i < MAX_FRAMES; i++) begin
			frame_page[i] = '0;
			frame_rank[i] = '0;
		end
		filled   = '0;
		hit_cnt  = '0;
		miss_cnt = '0;
	endfunction

	// age every filled frame more recent than k, then make k the newest
	function automatic void make_newest(int k);
		rank_t r;
		r = frame_rank[k];
		for (int i = 0; i < filled; i++)
			if (frame_rank[i] < r)
				frame_rank[i]++;
		frame_rank[k] = '0;
	endfunction

	function automatic lru_outcome_t lru_lookup(page_t pg, logic last);
		lru_outcome_t o;
		int  lim;
		int  slot;
		int  oldest;
		bit  found;
		o       = '{default: '0};
		found   = 1'b0;
		slot    = 0;
		lim     = (frames_cfg == 0) ? 1 : (frames_cfg > MAX_FRAMES) ? MAX_FRAMES : frames_cfg;
		for (int i = 0; i < filled; i++)
			if (!found && frame_page[i] == pg) begin
				found = 1'b1;
				slot  = i;
			end
		if (found) begin
			o.hit = 1'b1;
			make_newest(slot);
			if (hit_cnt != '1)
				hit_cnt++;
		end else begin
			if (filled < lim) begin
				slot             = filled;
				frame_page[slot] = pg;
				frame_rank[slot] = rank_t'(filled);
				filled++;
			end else begin
				// a lowered limit still replaces among every filled frame
				oldest = 0;
				for (int i = 0; i < filled; i++)
					if (frame_rank[i] > frame_rank[oldest])
						oldest = i;
				slot             = oldest;
				o.ev_valid       = 1'b1;
				o.ev_page        = frame_page[slot];
				frame_page[slot] = pg;
			end
			make_newest(slot);
			if (miss_cnt != '1)
				miss_cnt++;
		end
		o.slot       = slot_t'(slot);
		o.hits       = hit_cnt;
		o.misses     = miss_cnt;
		o.stream_end = last;
		if (last)
			flush_frames();
		return o;
	endfunction

	task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
	endtask

	// monitor: record accepted references first, then check the result transaction
	always @(posedge clk) begin
		lru_outcome_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				frames_cfg = cfg_data;
				cfg_writes++;
			end
			ref_taken = s_tvalid && s_tready;
			if (ref_taken)
				outcome_q.push_back(lru_lookup(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result with no reference pending, m_tdata %h",
							$realtime, m_tdata);
				end else begin
					want = outcome_q.pop_front();
					if (m_tdata[0] !== want.hit)
						note_mismatch("hit", 16'(want.hit), 16'(m_tdata[0]));
					if (m_tdata[3:1] !== want.slot)
						note_mismatch("frame_slot", 16'(want.slot), 16'(m_tdata[3:1]));
					if (m_tdata[4] !== want.ev_valid)
						note_mismatch("evicted_valid", 16'(want.ev_valid), 16'(m_tdata[4]));
					if (m_tdata[20:5] !== want.ev_page)
						note_mismatch("evicted_page", want.ev_page, m_tdata[20:5]);
					if (m_tdata[36:21] !== want.hits)
						note_mismatch("hit_total", want.hits, m_tdata[36:21]);
					if (m_tdata[52:37] !== want.misses)
						note_mismatch("miss_total", want.misses, m_tdata[52:37]);
					if (m_tdata[55:53] !== 3'b000)
						note_mismatch("pad bits", 16'h0, 16'(m_tdata[55:53]));
					if (m_tlast !== want.stream_end)
						note_mismatch("stream_end", 16'(want.stream_end), 16'(m_tlast));
					hits_seen    += want.hit;
					evicts_seen  += want.ev_valid;
					streams_seen += want.stream_end;
				end
			end
		end
	end

	// driver: hold the current reference until it is taken, then maybe advance
	always @(negedge clk) begin
		page_ref_t nxt;
		logic      give;
		if (arst_n && (!s_tvalid || ref_taken)) begin
			give = 1'b0;
			if (ref_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt  = ref_q.pop_front();
				give = 1'b1;
				s_tdata <= nxt.page;
				s_tlast <= nxt.last;
			end
			s_tvalid <= give;
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= snk_stall_pct);

	task automatic push_ref(page_t pg, logic last);
		ref_q.push_back('{page: pg, last: last});
	endtask

	task automatic wait_drained();
		while (ref_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_frames(cfg_t v);
		@(negedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : watchdog
		for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("lru_page_replacement test failed");
		$finish;
	end

	initial begin
		int    stream_left;
		int    ws_size;
		page_t ws_base;
		page_t pg;
		cfg_t  setting;
		int    phase_src [4];
		int    phase_snk [4];

		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		m_tready      = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		ref_taken     = 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		err_cnt       = 0;
		results_seen  = 0;
		hits_seen     = 0;
		evicts_seen   = 0;
		streams_seen  = 0;
		cfg_writes    = 0;
		frames_cfg    = cfg_t'(4);
		flush_frames();
		phase_src = '{0, 45, 0, 14};
		phase_snk = '{0, 0, 45, 14};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limit of four: fill, hit, evict, close the stream
		push_ref(16'h0000, 1'b0);
		push_ref(16'hFFFF, 1'b0);
		push_ref(16'h0000, 1'b0);
		push_ref(16'h8001, 1'b0);
		push_ref(16'h7FFE, 1'b0);
		push_ref(16'hFFFF, 1'b0);
		push_ref(16'h1234, 1'b0);
		push_ref(16'h0000, 1'b0);
		push_ref(16'h5555, 1'b0);
		push_ref(16'hAAAA, 1'b1);
		wait_drained();

		// zero frames acts as one
		write_frames(cfg_t'(0));
		push_ref(16'h0007, 1'b0);
		push_ref(16'h0007, 1'b0);
		push_ref(16'h0009, 1'b0);
		push_ref(16'h0009, 1'b1);
		wait_drained();

		// above the maximum acts as eight; fill all frames and leave the stream open
		write_frames(cfg_t'(15));
		for (int i = 1; i <= 8; i++)
			push_ref(page_t'(i), 1'b0);
		wait_drained();

		// limit lowered mid-stream
		write_frames(cfg_t'(2));
		push_ref(16'h0001, 1'b0);
		push_ref(16'h0100, 1'b0);
		push_ref(16'h0005, 1'b1);
		wait_drained();

		stream_left = 0;
		ws_size     = 1;
		ws_base     = '0;
		for (int ph = 0; ph < 4; ph++) begin
			for (int ch = 0; ch < 4; ch++) begin
				wait_drained();
				if (ph == 0 && ch == 0)
					setting = cfg_t'(MAX_FRAMES);
				else if ($urandom_range(4) == 0)
					setting = ($urandom_range(1)) ? cfg_t'(0) : cfg_t'($urandom_range(9, 15));
				else
					setting = cfg_t'($urandom_range(1, MAX_FRAMES));
				write_frames(setting);
				src_idle_pct  = phase_src[ph];
				snk_stall_pct = phase_snk[ph];
				// streams run across chunk edges, so some see the limit change mid-way
				for (int n = 0; n < CHUNK_REFS; n++) begin
					if (stream_left == 0) begin
						stream_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
						ws_size     = $urandom_range(1, 12);
						ws_base     = page_t'($urandom_range(0, 65535));
					end
					if ($urandom_range(99) < 15)
						pg = page_t'($urandom_range(0, 65535));
					else
						pg = ws_base ^ page_t'($urandom_range(0, ws_size - 1));
					push_ref(pg, stream_left == 1);
					stream_left--;
				end
			end
		end
		wait_drained();
		repeat (5) @(posedge clk);

		$display("Checked %0d results in %0d streams across %0d frame limit writes",
			results_seen, streams_seen, cfg_writes);
		$display("Saw %0d hits and %0d evictions under idle and stall phases",
			hits_seen, evicts_seen);
		if (err_cnt == 0 && outcome_q.size() == 0) begin
			$display("lru_page_replacement test passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", err_cnt, outcome_q.size());
			$display("lru_page_replacement test failed");
		end
		$finish;
	end

endmodule
